@@ hdl/uvcpfr_pkg.sv @@
`timescale 1ns / 1ps
package uvcpfr_pkg;

   // field widths
   localparam int DATA_BITS       = 8;
   localparam int PLEN_BITS       = 10;
   localparam int WRITE_ADDR_BITS = 24;
   localparam int MAX_FRAME_BITS  = 24;
   localparam int FRAMES_BITS     = 16;
   localparam int HDR_BITS        = 8;
   localparam int INFO_BITS       = 8;

   // defaults for the top-level parameters
   localparam int DEF_MAX_PACKET_BYTES = 1023;
   localparam int DEF_FRAME_ADDR_BITS  = 24;

   // packet format
   localparam logic [PLEN_BITS-1:0] MIN_PACKET = PLEN_BITS'(2);
   localparam logic [INFO_BITS-1:0] EOF_FLAG   = 8'h02;

   // words between front and back
   localparam int QUEUE_DEPTH = 2;

   // register interface
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_IDX_MAX_FRAME = 1'b0;

   typedef struct packed {
      logic                       write_en;
      logic [WRITE_ADDR_BITS-1:0] write_addr;
      logic [DATA_BITS-1:0]       write_data;
      logic                       frame_done;
   } rsp_word_type;

endpackage

@@ hdl/uvc_payload_frame_reassembler_core.sv @@
`timescale 1ns / 1ps
// Video payload reassembler. Packet bytes enter on the req_ channel, one word
// per byte, tagged with the packet length and an end mark on the last byte.
// Byte 0 is the header length, byte 1 the info flags. A packet is admitted on
// byte 0 when its payload fits in max_frame_bytes (csr_ register at 0x0); its
// payload bytes leave on the rsp_ channel as frame-buffer writes, and a packet
// ending with EOF set leaves a frame-done word carrying the frame count.
// Bytes that write nothing and end no frame produce no rsp_ word.
// Throughput: one byte per cycle while the queue is not full. The front
// classifier updates its packet state in the cycle a byte is accepted;
// results pass a 2-word queue and then the output register behind rsp_valid.
// When the receiver stalls, the output register holds and the queue absorbs
// words; req_ready drops only once the queue is full.
// Reset clears frame position, packet state, frame count, queue and the
// max_frame_bytes register (to 0, so no payload is admitted until written).
module uvc_payload_frame_reassembler_core #(
   parameter int MAX_PACKET_BYTES = uvcpfr_pkg::DEF_MAX_PACKET_BYTES,
   parameter int FRAME_ADDR_BITS  = uvcpfr_pkg::DEF_FRAME_ADDR_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [uvcpfr_pkg::DATA_BITS-1:0]       req_data_byte,
   input  logic [uvcpfr_pkg::PLEN_BITS-1:0]       req_packet_len,
   input  logic                                   req_packet_end,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_write_en,
   output logic [uvcpfr_pkg::WRITE_ADDR_BITS-1:0] rsp_write_addr,
   output logic [uvcpfr_pkg::DATA_BITS-1:0]       rsp_write_data,
   output logic                                   rsp_frame_done,
   output logic [uvcpfr_pkg::FRAMES_BITS-1:0]     rsp_frames_seen,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [uvcpfr_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [uvcpfr_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [uvcpfr_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   logic [uvcpfr_pkg::MAX_FRAME_BITS-1:0] max_frame_ff;
   logic                                  csr_hit, csr_wr;
   logic                                  accept, push, q_not_full, q_not_empty, pop;
   uvcpfr_pkg::rsp_word_type              push_word, head_word;

   // register select is the word index; byte offset bits are ignored
   assign csr_hit    = (csr_paddr[uvcpfr_pkg::CSR_ADDR_BITS-1] ==
                        uvcpfr_pkg::CSR_IDX_MAX_FRAME);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? uvcpfr_pkg::CSR_DATA_BITS'(max_frame_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= '0;
      end else if (csr_wr) begin
         max_frame_ff <= csr_pwdata[uvcpfr_pkg::MAX_FRAME_BITS-1:0];
      end
   end

   assign req_ready = q_not_full;
   assign accept    = req_valid && q_not_full;

   uvcpfr_front #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
      .FRAME_ADDR_BITS  (FRAME_ADDR_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_data_byte),
      .packet_len      (req_packet_len),
      .packet_end      (req_packet_end),
      .max_frame_bytes (max_frame_ff),
      .push            (push),
      .push_word       (push_word)
   );

   uvcpfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .not_full  (q_not_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_word (head_word)
   );

   uvcpfr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .word_valid      (q_not_empty),
      .word            (head_word),
      .word_pop        (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_write_en    (rsp_write_en),
      .rsp_write_addr  (rsp_write_addr),
      .rsp_write_data  (rsp_write_data),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_frames_seen (rsp_frames_seen)
   );

endmodule

@@ hdl/uvcpfr_front.sv @@
`timescale 1ns / 1ps
module uvcpfr_front #(
   parameter int MAX_PACKET_BYTES = uvcpfr_pkg::DEF_MAX_PACKET_BYTES,
   parameter int FRAME_ADDR_BITS  = uvcpfr_pkg::DEF_FRAME_ADDR_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic [uvcpfr_pkg::DATA_BITS-1:0]       data_byte,
   input  logic [uvcpfr_pkg::PLEN_BITS-1:0]       packet_len,
   input  logic                                   packet_end,
   input  logic [uvcpfr_pkg::MAX_FRAME_BITS-1:0]  max_frame_bytes,
   output logic                                   push,
   output uvcpfr_pkg::rsp_word_type               push_word
);

   localparam int IDX_BITS = $clog2(MAX_PACKET_BYTES + 1);
   localparam int CMP_BITS = (IDX_BITS > uvcpfr_pkg::PLEN_BITS) ? IDX_BITS
                                                                 : uvcpfr_pkg::PLEN_BITS;
   localparam int SUM_BITS = ((FRAME_ADDR_BITS > uvcpfr_pkg::MAX_FRAME_BITS) ?
                              FRAME_ADDR_BITS : uvcpfr_pkg::MAX_FRAME_BITS) + 1;
   localparam int POS_WIDE = (FRAME_ADDR_BITS > uvcpfr_pkg::WRITE_ADDR_BITS) ?
                             FRAME_ADDR_BITS : uvcpfr_pkg::WRITE_ADDR_BITS;
   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(MAX_PACKET_BYTES);

   logic [IDX_BITS-1:0]                   idx_ff, idx_in;
   logic [uvcpfr_pkg::HDR_BITS-1:0]       hdr_ff, hdr_in;
   logic [uvcpfr_pkg::INFO_BITS-1:0]      info_ff, info_in;
   logic                                  adm_ff, adm_in;
   logic [FRAME_ADDR_BITS-1:0]            pos_ff, pos_in;

   logic                                  first_byte, second_byte, long_pkt;
   logic [uvcpfr_pkg::PLEN_BITS-1:0]      body_bytes;
   logic [SUM_BITS-1:0]                   frame_end;
   logic                                  wen, done;
   logic [CMP_BITS-1:0]                   idx_cmp, hdr_cmp, plen_cmp;
   logic [POS_WIDE-1:0]                   pos_wide;

   always_comb begin
      first_byte  = (idx_ff == '0);
      second_byte = (idx_ff == IDX_BITS'(1));
      long_pkt    = (packet_len >= uvcpfr_pkg::MIN_PACKET);

      hdr_in  = first_byte ? data_byte : hdr_ff;
      info_in = first_byte ? '0 : (second_byte ? data_byte : info_ff);

      // admission: payload must be non-empty and fit in what is left of the frame
      body_bytes = packet_len - uvcpfr_pkg::PLEN_BITS'(data_byte);
      frame_end  = SUM_BITS'(pos_ff) + SUM_BITS'(body_bytes);
      if (first_byte) begin
         adm_in = long_pkt && (packet_len > uvcpfr_pkg::PLEN_BITS'(data_byte)) &&
                  (frame_end <= SUM_BITS'(max_frame_bytes));
      end else begin
         adm_in = adm_ff;
      end

      idx_cmp  = CMP_BITS'(idx_ff);
      hdr_cmp  = CMP_BITS'(hdr_in);
      plen_cmp = CMP_BITS'(packet_len);
      wen  = long_pkt && adm_in && (idx_cmp >= hdr_cmp) && (idx_cmp < plen_cmp);
      done = packet_end && long_pkt && ((info_in & uvcpfr_pkg::EOF_FLAG) != '0);

      if (done) begin
         pos_in = '0;
      end else if (wen) begin
         pos_in = pos_ff + FRAME_ADDR_BITS'(1);
      end else begin
         pos_in = pos_ff;
      end

      // index saturates if the end mark never comes
      if (packet_end) begin
         idx_in = '0;
      end else if (idx_ff < IDX_LAST) begin
         idx_in = idx_ff + IDX_BITS'(1);
      end else begin
         idx_in = idx_ff;
      end

      pos_wide             = POS_WIDE'(pos_ff);
      push                 = accept && (wen || done);
      push_word.write_en   = wen;
      push_word.write_addr = wen ? pos_wide[uvcpfr_pkg::WRITE_ADDR_BITS-1:0] : '0;
      push_word.write_data = wen ? data_byte : '0;
      push_word.frame_done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         hdr_ff  <= '0;
         info_ff <= '0;
         adm_ff  <= 1'b0;
         pos_ff  <= '0;
      end else if (accept) begin
         idx_ff  <= idx_in;
         hdr_ff  <= hdr_in;
         info_ff <= info_in;
         adm_ff  <= adm_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

@@ hdl/uvcpfr_queue.sv @@
`timescale 1ns / 1ps
module uvcpfr_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  uvcpfr_pkg::rsp_word_type push_word,
   output logic                     not_full,
   input  logic                     pop,
   output logic                     not_empty,
   output uvcpfr_pkg::rsp_word_type head_word
);

   localparam int DEPTH    = uvcpfr_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

   uvcpfr_pkg::rsp_word_type slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      not_full  = (count_ff != CNT_BITS'(DEPTH));
      not_empty = (count_ff != '0);
      head_word = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end

      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/uvcpfr_back.sv @@
`timescale 1ns / 1ps
module uvcpfr_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 word_valid,
   input  uvcpfr_pkg::rsp_word_type             word,
   output logic                                 word_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_write_en,
   output logic [uvcpfr_pkg::WRITE_ADDR_BITS-1:0] rsp_write_addr,
   output logic [uvcpfr_pkg::DATA_BITS-1:0]     rsp_write_data,
   output logic                                 rsp_frame_done,
   output logic [uvcpfr_pkg::FRAMES_BITS-1:0]   rsp_frames_seen
);

   logic                                out_valid_ff, out_valid_in;
   uvcpfr_pkg::rsp_word_type            out_word_ff;
   logic [uvcpfr_pkg::FRAMES_BITS-1:0]  frames_ff, frames_in;
   logic [uvcpfr_pkg::FRAMES_BITS-1:0]  seen_ff;

   always_comb begin
      word_pop     = word_valid && (!out_valid_ff || rsp_ready);
      out_valid_in = word_pop || (out_valid_ff && !rsp_ready);
      frames_in    = frames_ff + uvcpfr_pkg::FRAMES_BITS'(word.frame_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         frames_ff    <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (word_pop) begin
            frames_ff <= frames_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (word_pop) begin
         out_word_ff <= word;
         seen_ff     <= frames_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_write_en    = out_word_ff.write_en;
   assign rsp_write_addr  = out_word_ff.write_addr;
   assign rsp_write_data  = out_word_ff.write_data;
   assign rsp_frame_done  = out_word_ff.frame_done;
   assign rsp_frames_seen = seen_ff;

endmodule
